// ===== hw/rtl/adsp_pkg.sv =====
// shared types, codes and helpers of the advertising data structure parser
// no dependencies; imported by every module of the block
`default_nettype none

package adsp_pkg;

  // longest packet payload the parser walks; longer lengths saturate
  localparam logic [7:0] MAX_PACKET_BYTES = 8'd255;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCONN_EVENT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_AD      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROVISIONING_AD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BEACON_AD       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROV_ENABLE     = 3'd4;
  localparam int unsigned CFG_DATA_W = 8;

  // byte roles
  localparam logic [1:0] ROLE_LENGTH  = 2'd0;
  localparam logic [1:0] ROLE_TYPE    = 2'd1;
  localparam logic [1:0] ROLE_VALUE   = 2'd2;
  localparam logic [1:0] ROLE_IGNORED = 2'd3;

  // structure classes
  localparam logic [1:0] CLS_MESSAGE      = 2'd0;
  localparam logic [1:0] CLS_PROVISIONING = 2'd1;
  localparam logic [1:0] CLS_BEACON       = 2'd2;
  localparam logic [1:0] CLS_OTHER        = 2'd3;

  // packet status
  localparam logic [2:0] ST_RUN  = 3'd0;
  localparam logic [2:0] ST_OK   = 3'd1;
  localparam logic [2:0] ST_ZERO = 3'd2;
  localparam logic [2:0] ST_BAD  = 3'd3;
  localparam logic [2:0] ST_DROP = 3'd4;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       first_byte;
    logic [2:0] event_kind;
    logic [7:0] packet_length;
  } in_item_t;

  typedef struct packed {
    logic [1:0] byte_role;
    logic [1:0] structure_class;
    logic [7:0] echoed_byte;
    logic       structure_end;
    logic [2:0] packet_status;
  } out_item_t;

  typedef struct packed {
    logic [2:0] nonconn_event_code;
    logic [7:0] message_ad_code;
    logic [7:0] provisioning_ad_code;
    logic [7:0] beacon_ad_code;
    logic       provisioning_enable;
  } cfg_t;

  // message wins over provisioning, provisioning over beacon
  function automatic logic [1:0] class_of(input logic [7:0] code, input cfg_t cfg);
    logic [1:0] cls;
    cls = CLS_OTHER;
    if (code == cfg.message_ad_code) begin
      cls = CLS_MESSAGE;
    end else if (cfg.provisioning_enable && code == cfg.provisioning_ad_code) begin
      cls = CLS_PROVISIONING;
    end else if (code == cfg.beacon_ad_code) begin
      cls = CLS_BEACON;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/adv_data_structure_parser_core.sv =====
// top level of the advertising data structure parser
// depends on adsp_pkg, adsp_cfg_regs and adsp_parser
//
//   port group  direction  handshake            payload
//   in_         in         in_valid / in_ready  in_item   (in_item_t)
//   out_        out        out_valid/out_ready  out_item  (out_item_t)
//   cfg_        in         cfg_we               cfg_idx, cfg_wdata
//
// one item a cycle unless the output stalls: each byte is classed by a single pass of logic
// between the parse state registers and the result register
// the result register frees itself in the same cycle it is taken, so a new
// item enters while the old result leaves
// only a stalled out_ready with a full result register holds in_ready low
// synchronous active-low reset: no packet open, default codes restored
`default_nettype none

module adv_data_structure_parser_core import adsp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // item input
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_item,
  // result output
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_item,
  // configuration writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg;

  // event type, AD type codes and provisioning enable; the user writes them only while idle, not enforced here
  adsp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // structure walk and result register
  adsp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/adsp_cfg_regs.sv =====
// configuration register file of the advertising data structure parser
// depends on adsp_pkg
`default_nettype none

module adsp_cfg_regs import adsp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nonconn_event_code   <= 3'd3;
      cfg_r.message_ad_code      <= 8'd42;
      cfg_r.provisioning_ad_code <= 8'd41;
      cfg_r.beacon_ad_code       <= 8'd43;
      cfg_r.provisioning_enable  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_NONCONN_EVENT:   cfg_r.nonconn_event_code   <= cfg_wdata[2:0];
        CFG_MESSAGE_AD:      cfg_r.message_ad_code      <= cfg_wdata;
        CFG_PROVISIONING_AD: cfg_r.provisioning_ad_code <= cfg_wdata;
        CFG_BEACON_AD:       cfg_r.beacon_ad_code       <= cfg_wdata;
        CFG_PROV_ENABLE:     cfg_r.provisioning_enable  <= cfg_wdata[0];
        default: ; // unmapped index, write dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== hw/rtl/adsp_parser.sv =====
// per-byte walk of length-type-value structures with its result register
// depends on adsp_pkg
`default_nettype none

module adsp_parser import adsp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  typedef enum logic [1:0] {
    PH_LEN   = 2'd0,
    PH_TYPE  = 2'd1,
    PH_VALUE = 2'd2,
    PH_IDLE  = 2'd3
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] blp_r, blp_nxt;     // packet bytes left, current one included
  logic [7:0] bls_r, bls_nxt;     // type and value bytes still due
  logic [1:0] cls_r, cls_nxt;
  logic [2:0] fstat_r, fstat_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r, out_item_nxt;

  logic       in_fire;
  phase_t     ph_cur;
  logic [7:0] blp_cur, bls_cur, plen_sat, b;
  logic [1:0] cls_cur;
  logic [2:0] fstat_cur;
  logic       kind_ok;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    b        = in_item.payload_byte;
    plen_sat = (in_item.packet_length > MAX_PACKET_BYTES) ? MAX_PACKET_BYTES
                                                          : in_item.packet_length;
    kind_ok  = (in_item.event_kind == cfg.nonconn_event_code);

    // a first byte restarts the walk before the byte itself is classed
    ph_cur    = phase_r;
    blp_cur   = blp_r;
    bls_cur   = bls_r;
    cls_cur   = cls_r;
    fstat_cur = fstat_r;
    if (in_item.first_byte) begin
      blp_cur   = plen_sat;
      bls_cur   = 8'd0;
      cls_cur   = CLS_OTHER;
      ph_cur    = kind_ok ? PH_LEN : PH_IDLE;
      fstat_cur = kind_ok ? ST_OK : ST_DROP;
    end

    phase_nxt = ph_cur;
    blp_nxt   = blp_cur;
    bls_nxt   = bls_cur;
    cls_nxt   = cls_cur;
    fstat_nxt = fstat_cur;

    out_item_nxt.byte_role       = ROLE_IGNORED;
    out_item_nxt.structure_class = CLS_OTHER;
    out_item_nxt.echoed_byte     = b;
    out_item_nxt.structure_end   = 1'b0;
    out_item_nxt.packet_status   = fstat_cur;

    unique case (ph_cur)
      PH_LEN: begin
        if (blp_cur <= 8'd1) begin
          // trailing single byte or empty packet
          blp_nxt   = 8'd0;
          phase_nxt = PH_IDLE;
          fstat_nxt = ST_OK;
          out_item_nxt.packet_status = ST_OK;
        end else if (b == 8'd0) begin
          out_item_nxt.byte_role     = ROLE_LENGTH;
          phase_nxt = PH_IDLE;
          fstat_nxt = ST_ZERO;
          out_item_nxt.packet_status = ST_ZERO;
        end else if (b > blp_cur - 8'd1) begin
          out_item_nxt.byte_role     = ROLE_LENGTH;
          phase_nxt = PH_IDLE;
          fstat_nxt = ST_BAD;
          out_item_nxt.packet_status = ST_BAD;
        end else begin
          out_item_nxt.byte_role     = ROLE_LENGTH;
          bls_nxt   = b;
          blp_nxt   = blp_cur - 8'd1;
          phase_nxt = PH_TYPE;
          out_item_nxt.packet_status = ST_RUN;
        end
      end
      PH_TYPE, PH_VALUE: begin
        if (ph_cur == PH_TYPE) begin
          cls_nxt = class_of(b, cfg);
          out_item_nxt.byte_role = ROLE_TYPE;
        end else begin
          out_item_nxt.byte_role = ROLE_VALUE;
        end
        out_item_nxt.structure_class = cls_nxt;
        bls_nxt = (bls_cur != 8'd0) ? bls_cur - 8'd1 : 8'd0;
        blp_nxt = (blp_cur != 8'd0) ? blp_cur - 8'd1 : 8'd0;
        out_item_nxt.packet_status = ST_RUN;
        if (bls_nxt == 8'd0) begin
          out_item_nxt.structure_end = 1'b1;
          if (blp_nxt == 8'd0) begin
            phase_nxt = PH_IDLE;
            fstat_nxt = ST_OK;
            out_item_nxt.packet_status = ST_OK;
          end else begin
            phase_nxt = PH_LEN;
          end
        end else begin
          phase_nxt = PH_VALUE;
        end
      end
      default: ; // idle: byte ignored with the last end status
    endcase

    out_valid_nxt = in_fire || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEN;
      blp_r       <= 8'd0;
      bls_r       <= 8'd0;
      cls_r       <= CLS_OTHER;
      fstat_r     <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        phase_r <= phase_nxt;
        blp_r   <= blp_nxt;
        bls_r   <= bls_nxt;
        cls_r   <= cls_nxt;
        fstat_r <= fstat_nxt;
      end
    end
    if (in_fire) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ===== hw/rtl/adsp_checker.sv =====
// port-level checks of the advertising data structure parser
// depends on adsp_pkg; bound to adv_data_structure_parser_core
`default_nettype none

module adsp_checker import adsp_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_item,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);

  // a waiting result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // an accepted item shows its result next cycle with its byte echoed
  a_echo: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid && out_item.echoed_byte == $past(in_item.payload_byte))
    else $error("result missing or echoed byte wrong");

  // an empty result register never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result waiting");

  // structure end only on type or value bytes, ignored bytes are class other
  a_roles: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.structure_end || out_item.byte_role == ROLE_IGNORED) |->
      (out_item.structure_end && (out_item.byte_role == ROLE_TYPE ||
        out_item.byte_role == ROLE_VALUE)) ||
      (!out_item.structure_end && out_item.structure_class == CLS_OTHER))
    else $error("structure end or ignored byte tagged inconsistently");

endmodule

bind adv_data_structure_parser_core adsp_checker u_adsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire
